[rtl/mss_pkg.sv]
// Shared types and constants for the masked signature scanner.
`default_nettype none

package mss_pkg;

	// Field and register widths.
	localparam int PLEN_W   = 7;
	localparam int SKIP_W   = 16;
	localparam int REGION_W = 32;
	localparam int ADDR_W   = 32;
	localparam int BYTES_W  = 33;
	localparam int MATCH_W  = 17;
	localparam int INDEX_W  = 6;

	// Register reset values.
	localparam logic [PLEN_W-1:0]   PLEN_RESET   = 7'd40;
	localparam logic [SKIP_W-1:0]   SKIP_RESET   = 16'd0;
	localparam logic [REGION_W-1:0] REGION_RESET = 32'hE5_2000;
	localparam logic [ADDR_W-1:0]   START_RESET  = 32'h40_1000;

	// Request kinds carried in the input tuser.
	typedef enum logic [1:0] {
		REQ_LOAD  = 2'd0,
		REQ_SCAN  = 2'd1,
		REQ_START = 2'd2
	} req_t;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		CFG_PATTERN_LENGTH = 2'd0,
		CFG_SKIP_COUNT     = 2'd1,
		CFG_REGION_LENGTH  = 2'd2,
		CFG_START_ADDRESS  = 2'd3
	} cfg_reg_t;

	// One pattern position: the byte and whether it must match.
	typedef struct packed {
		logic       care;
		logic [7:0] data;
	} pat_entry_t;

	// One scan result.
	typedef struct packed {
		logic              found;
		logic [ADDR_W-1:0] address;
	} result_t;

endpackage

`default_nettype wire

[rtl/mss_cell.sv]
// One compare cell: holds one window byte and the pattern entry aligned to it.
`default_nettype none

module mss_cell (
	input  wire logic               clk,
	input  wire logic               shift,
	input  wire logic [7:0]         win_in,
	input  wire mss_pkg::pat_entry_t pat_in,
	output logic [7:0]              win_out,
	output logic                    hit
);

	logic [7:0]          win_q;
	mss_pkg::pat_entry_t pat_q;

	// The window byte moves one cell older on every accepted scan byte.
	always_ff @(posedge clk) begin
		if (shift) begin
			win_q <= win_in;
		end
	end

	// The aligned pattern entry is refreshed every cycle.
	always_ff @(posedge clk) begin
		pat_q <= pat_in;
	end

	// A wildcard always hits; otherwise the bytes must be equal.
	assign hit     = !pat_q.care || (win_q == pat_q.data);
	assign win_out = win_q;

endmodule

`default_nettype wire

[rtl/mss_align.sv]
// Pattern store and the shifter that lines each pattern entry up with its window cell.
`default_nettype none

module mss_align #(
	parameter int MAX_PATTERN = 64
) (
	input  wire logic                            clk,
	input  wire logic                            wr_en,
	input  wire logic [(MAX_PATTERN > 1 ? $clog2(MAX_PATTERN) : 1)-1:0] wr_addr,
	input  wire mss_pkg::pat_entry_t             wr_entry,
	input  wire logic [mss_pkg::PLEN_W-1:0]      n_eff,
	output mss_pkg::pat_entry_t                  aligned [MAX_PATTERN]
);

	localparam int EW = $bits(mss_pkg::pat_entry_t);
	localparam int VW = MAX_PATTERN * EW;
	localparam int SW = $clog2(VW + 1);

	mss_pkg::pat_entry_t mem_q [MAX_PATTERN];
	logic [VW-1:0]       rev;
	logic [VW-1:0]       shifted;
	logic [SW-1:0]       shamt;

	// Pattern entries are written one at a time by load transfers.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_entry;
		end
	end

	// Cell k (age k) compares against entry n-1-k. Reversing the store and
	// shifting it right by MAX_PATTERN-n entries gives exactly that; cells at
	// or beyond n receive zeros, which read as wildcards.
	always_comb begin
		for (int i = 0; i < MAX_PATTERN; i++) begin
			rev[i*EW +: EW] = mem_q[MAX_PATTERN-1-i];
		end
		shamt   = SW'(EW * (MAX_PATTERN - int'(n_eff)));
		shifted = rev >> shamt;
		for (int k = 0; k < MAX_PATTERN; k++) begin
			aligned[k] = shifted[k*EW +: EW];
		end
	end

endmodule

`default_nettype wire

[rtl/masked_signature_scanner.sv]
// Top level of the masked signature scanner: control, counters, cell row and result queue.
// A result passes stage 1 and the result queue registers before it shows on m_tvalid.
// Throughput: one input item per cycle; the two-entry result queue stalls input only
//   while it is full or about to fill.
// Reset (arst_n low, asynchronous): registers take their default values, counters clear,
//   no scan is armed and the result queue empties. Pattern entries are not cleared.
`default_nettype none

module masked_signature_scanner #(
	parameter int MAX_PATTERN = 64,
	parameter int ADDR_BITS   = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Input stream.
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,  // index[5:0], value[13:6], care[14], zero[15]
	input  wire logic [1:0]  s_tuser,  // req_type[1:0]
	// Result stream.
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,  // address[31:0]
	output logic             m_tuser,  // found[0]
	// Configuration writes.
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	localparam int PLW = mss_pkg::PLEN_W;
	localparam int BW  = mss_pkg::BYTES_W;
	localparam int MW  = mss_pkg::MATCH_W;
	localparam int AW  = mss_pkg::ADDR_W;
	localparam int PAW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int AMW = (ADDR_BITS < AW) ? ADDR_BITS : AW;
	localparam logic [AW-1:0] ADDR_MASK = AW'((64'd1 << AMW) - 64'd1);

	// Configuration registers.
	logic [PLW-1:0]                 plen_q;
	logic [mss_pkg::SKIP_W-1:0]     skip_q;
	logic [mss_pkg::REGION_W-1:0]   region_q;
	logic [AW-1:0]                  start_q;

	// Scan state.
	logic [BW-1:0]  bytes_q;
	logic [MW-1:0]  matches_q;
	logic           done_q;

	// Stage 1 of an admitted scan byte.
	logic           valid_s1;
	logic           ge_s1;
	logic [BW-1:0]  off_s1;

	// Result queue.
	mss_pkg::result_t ent_q [2];
	logic [1:0]       cnt_q;

	logic              acc;
	logic              is_load;
	logic              is_start;
	logic              scan_acc;
	logic [7:0]        in_value;
	logic [PLW-1:0]    n_eff;
	logic [BW-1:0]     bytes_next;
	logic              load_en;
	mss_pkg::pat_entry_t load_entry;
	mss_pkg::pat_entry_t aligned [MAX_PATTERN];
	logic [7:0]        win [MAX_PATTERN+1];
	logic [MAX_PATTERN-1:0] hit;
	logic              match;
	logic [MW-1:0]     m_next;
	logic              push;
	logic              inc_match;
	mss_pkg::result_t  res;
	logic              pop;
	logic              wr_ix;

	// Input decode.
	assign acc      = s_tvalid && s_tready;
	assign is_load  = (s_tuser == mss_pkg::REQ_LOAD);
	assign is_start = (s_tuser == mss_pkg::REQ_START);
	assign scan_acc = acc && (s_tuser == mss_pkg::REQ_SCAN) && !done_q;
	assign in_value = s_tdata[13:6];

	// Accept while the queue can still hold every result that may be in flight.
	assign s_tready = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && !(valid_s1 && !done_q));

	// Effective pattern length: zero counts as one, long values saturate.
	always_comb begin
		if (plen_q == '0) begin
			n_eff = PLW'(1);
		end else if (int'(plen_q) > MAX_PATTERN) begin
			n_eff = PLW'(MAX_PATTERN);
		end else begin
			n_eff = plen_q;
		end
	end

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q   <= mss_pkg::PLEN_RESET;
			skip_q   <= mss_pkg::SKIP_RESET;
			region_q <= mss_pkg::REGION_RESET;
			start_q  <= mss_pkg::START_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mss_pkg::CFG_PATTERN_LENGTH: plen_q   <= cfg_data[PLW-1:0];
				mss_pkg::CFG_SKIP_COUNT:     skip_q   <= cfg_data[mss_pkg::SKIP_W-1:0];
				mss_pkg::CFG_REGION_LENGTH:  region_q <= cfg_data[mss_pkg::REGION_W-1:0];
				mss_pkg::CFG_START_ADDRESS:  start_q  <= cfg_data[AW-1:0];
				default: ;
			endcase
		end
	end

	// Pattern store and alignment.
	assign load_en         = acc && is_load && (int'(s_tdata[5:0]) < MAX_PATTERN);
	assign load_entry.care = s_tdata[14];
	assign load_entry.data = in_value;

	mss_align #(
		.MAX_PATTERN(MAX_PATTERN)
	) u_align (
		.clk      (clk),
		.wr_en    (load_en),
		.wr_addr  (PAW'(s_tdata[5:0])),
		.wr_entry (load_entry),
		.n_eff    (n_eff),
		.aligned  (aligned)
	);

	// Row of cells; the newest byte enters cell 0 and ages toward the end.
	assign win[0] = in_value;

	for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
		mss_cell u_cell (
			.clk     (clk),
			.shift   (scan_acc),
			.win_in  (win[k]),
			.pat_in  (aligned[k]),
			.win_out (win[k+1]),
			.hit     (hit[k])
		);
	end

	assign match = &hit;

	// Candidate offset for the byte being admitted.
	assign bytes_next = bytes_q + BW'(1);

	always_ff @(posedge clk) begin
		if (scan_acc) begin
			ge_s1  <= (bytes_next >= BW'(n_eff));
			off_s1 <= bytes_next - BW'(n_eff);
		end
	end

	// Stage 1 decision: report a match, report the end of the region, or go on.
	assign m_next = (matches_q == '1) ? matches_q : (matches_q + MW'(1));

	always_comb begin
		push      = 1'b0;
		inc_match = 1'b0;
		res       = '0;
		if (valid_s1 && !done_q) begin
			if (region_q == '0) begin
				push = 1'b1;
			end else if (ge_s1) begin
				if (off_s1 >= BW'(region_q)) begin
					push = 1'b1;
				end else begin
					inc_match = match;
					if (match && (m_next > MW'(skip_q))) begin
						push        = 1'b1;
						res.found   = 1'b1;
						res.address = (start_q + off_s1[AW-1:0]) & ADDR_MASK;
					end else if (off_s1 == BW'(region_q - 32'd1)) begin
						push = 1'b1;
					end
				end
			end
		end
	end

	// Scan counters; a start transfer overrides anything the decision writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_q   <= '0;
			matches_q <= '0;
			done_q    <= 1'b1;
			valid_s1  <= 1'b0;
		end else begin
			valid_s1 <= scan_acc;
			if (acc && is_start) begin
				bytes_q   <= '0;
				matches_q <= '0;
				done_q    <= 1'b0;
			end else begin
				if (scan_acc) begin
					bytes_q <= bytes_next;
				end
				if (inc_match) begin
					matches_q <= m_next;
				end
				if (push) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// Two-entry result queue, head in entry 0.
	assign pop   = m_tvalid && m_tready;
	assign wr_ix = (cnt_q == 2'd1) && !pop;

	always_ff @(posedge clk) begin
		if (push && !wr_ix) begin
			ent_q[0] <= res;
		end else if (pop) begin
			ent_q[0] <= ent_q[1];
		end
		if (push && wr_ix) begin
			ent_q[1] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	assign m_tvalid = (cnt_q != 2'd0);
	assign m_tdata  = ent_q[0].address;
	assign m_tuser  = ent_q[0].found;

	// The queue never holds more than two results.
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("result queue count out of range");

	// A result is never pushed into a full queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (cnt_q != 2'd2))
		else $error("result pushed into a full queue");

	// A pushed result ends the scan unless a start transfer rearms it.
	a_done_after_push: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !(acc && is_start)) |=> done_q)
		else $error("scan not ended after a result");

	// A not-found result carries a zero address.
	a_notfound_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata == '0))
		else $error("not-found result with nonzero address");

	// No scan byte is admitted once the scan has ended.
	a_no_scan_done: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !scan_acc)
		else $error("scan byte admitted after the scan ended");

endmodule

`default_nettype wire
